[design/cfa_pkg.sv]
// Package for the contact force accumulator: payload structs, register
// indexes, fixed-point constants and controller/datapath command types.
// No dependencies.
package cfa_pkg;

	localparam int ACC_W   = 48;           // accumulator width, 40..64, even
	localparam int HALF_W  = ACC_W / 2;    // partial-product piece width
	localparam int SQ_W    = 2 * ACC_W;    // sum of squares width
	localparam int FORCE_W = 40;
	localparam int DT_FRAC = 24;           // Q8.24 dt against Q24.16 force
	localparam int LOW_W   = 16;           // M bits below the saturation compare
	localparam int MH_W    = ACC_W - LOW_W;
	localparam int CMP_W   = (MH_W > 32) ? MH_W : 32;
	localparam int CNT_MAX = (ACC_W > FORCE_W) ? ACC_W : FORCE_W;
	localparam int CNT_W   = $clog2(CNT_MAX);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 40;

	localparam logic [31:0] DT_SIXTIETH = 32'd279620;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Y = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_Z = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TH   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TH   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DT  = 4'd7;

	// kind of reading produced at the end of a step
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_OFF   = 2'd1;
	localparam logic [1:0] KIND_FORCE = 2'd2;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] imp_x;
		logic signed [31:0] imp_y;
		logic signed [31:0] imp_z;
		logic               sensor_is_second;
		logic [31:0]        contact_dt;
		logic               last;
		logic               empty_step;
	} cfa_in_t;

	typedef struct packed {
		logic [FORCE_W-1:0] force_res;
		logic               in_contact;
		logic               valid_res;
	} cfa_out_t;

	typedef struct packed {
		logic             load;
		logic             gate;
		logic             mul;
		logic             acc;
		logic             sq;
		logic             sqrt;
		logic             div;
		logic             emit;
		logic             first;
		logic [CNT_W-1:0] cnt;
		logic [1:0]       kind;
	} cfa_cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
		logic enable;
	} cfa_stat_t;

endpackage

[design/cfa_ctrl.sv]
// Controller for the contact force accumulator: sequencing state machine,
// step counter and output valid flag. Depends on cfa_pkg.
module cfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cfa_pkg::cfa_stat_t stat,
	output cfa_pkg::cfa_cmd_t  cmd
);
	import cfa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GATE = 3'd1;
	localparam logic [2:0] ST_MULG = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_SQ   = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       kind_q;
	logic             out_valid_q;
	logic             accept;
	logic             slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// commands to the datapath
	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.gate  = (state_q == ST_GATE);
		cmd.mul   = (state_q == ST_MULG);
		cmd.acc   = (state_q == ST_ACC);
		cmd.sq    = (state_q == ST_SQ);
		cmd.sqrt  = (state_q == ST_SQRT);
		cmd.div   = (state_q == ST_DIV);
		cmd.emit  = (state_q == ST_FIN) && slot_free;
		cmd.first = (cnt_q == '0);
		cmd.cnt   = cnt_q;
		cmd.kind  = kind_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			kind_q  <= KIND_EMPTY;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_GATE;
				end
				ST_GATE: begin
					cnt_q <= '0;
					if (stat.empty) begin
						kind_q  <= KIND_EMPTY;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MULG;
					end
				end
				ST_MULG: begin
					if (cnt_q == CNT_W'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACC: begin
					if (!stat.last) begin
						state_q <= ST_IDLE;
					end else if (!stat.enable) begin
						kind_q  <= KIND_OFF;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (cnt_q == CNT_W'(8)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CNT_W'(ACC_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(FORCE_W - 1)) begin
						cnt_q   <= '0;
						kind_q  <= KIND_FORCE;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("result written over a stalled result");
	a_accept_gate: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_GATE)
		else $error("accepted item not sequenced");
	a_sq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ || state_q == ST_MULG) |-> cnt_q <= CNT_W'(8))
		else $error("step counter out of range");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

[design/cfa_dp.sv]
// Datapath for the contact force accumulator: config registers, distance
// gate, saturating accumulators, shared multiplier, serial sqrt and divider.
// Depends on cfa_pkg.
module cfa_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  cfa_pkg::cfa_in_t                 in_data,
	input  cfa_pkg::cfa_cmd_t                cmd,
	output cfa_pkg::cfa_stat_t               stat,
	output cfa_pkg::cfa_out_t                out_data
);
	import cfa_pkg::*;

	// configuration
	logic signed [31:0]  sensor_x_q, sensor_y_q, sensor_z_q, radius_q;
	logic [FORCE_W-1:0]  min_th_q, max_th_q;
	logic                enable_q;
	logic [31:0]         step_dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_x_q <= '0;
			sensor_y_q <= '0;
			sensor_z_q <= '0;
			radius_q   <= -32'sd65536;
			min_th_q   <= '0;
			max_th_q   <= FORCE_W'(64'd6553600000);
			enable_q   <= 1'b1;
			step_dt_q  <= DT_SIXTIETH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSOR_X: sensor_x_q <= cfg_data[31:0];
				REG_SENSOR_Y: sensor_y_q <= cfg_data[31:0];
				REG_SENSOR_Z: sensor_z_q <= cfg_data[31:0];
				REG_RADIUS:   radius_q   <= cfg_data[31:0];
				REG_MIN_TH:   min_th_q   <= cfg_data[FORCE_W-1:0];
				REG_MAX_TH:   max_th_q   <= cfg_data[FORCE_W-1:0];
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_STEP_DT:  step_dt_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// input item register
	cfa_in_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
	end

	assign stat.empty  = item_q.empty_step;
	assign stat.last   = item_q.last;
	assign stat.enable = enable_q;

	// distance gate: per-axis magnitudes
	logic signed [32:0] dx, dy, dz;
	logic [32:0]        mx, my, mz;
	logic [32:0]        ur;
	logic [31:0]        ax_q, ay_q, az_q;
	logic               outside_q;

	assign dx = 33'(sensor_x_q) - 33'(item_q.pos_x);
	assign dy = 33'(sensor_y_q) - 33'(item_q.pos_y);
	assign dz = 33'(sensor_z_q) - 33'(item_q.pos_z);
	assign mx = dx[32] ? 33'(-dx) : 33'(dx);
	assign my = dy[32] ? 33'(-dy) : 33'(dy);
	assign mz = dz[32] ? 33'(-dz) : 33'(dz);
	assign ur = {1'b0, radius_q};

	always_ff @(posedge clk) begin
		if (cmd.gate) begin
			ax_q      <= mx[31:0];
			ay_q      <= my[31:0];
			az_q      <= mz[31:0];
			outside_q <= (mx >= ur) || (my >= ur) || (mz >= ur);
		end
	end

	// accumulators and their magnitudes
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic [31:0]             wdt_q;
	logic [ACC_W-1:0]        mag_x, mag_y, mag_z;

	assign mag_x = acc_x_q[ACC_W-1] ? ACC_W'(-acc_x_q) : ACC_W'(acc_x_q);
	assign mag_y = acc_y_q[ACC_W-1] ? ACC_W'(-acc_y_q) : ACC_W'(acc_y_q);
	assign mag_z = acc_z_q[ACC_W-1] ? ACC_W'(-acc_z_q) : ACC_W'(acc_z_q);

	// shared 32x32 multiplier with operand select
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   prod;
	logic [7:0]    sh;
	logic [SQ_W-1:0] prod_sh;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sh    = '0;
		if (cmd.mul) begin
			case (cmd.cnt[1:0])
				2'd0: begin mul_a = radius_q; mul_b = radius_q; end
				2'd1: begin mul_a = ax_q; mul_b = ax_q; end
				2'd2: begin mul_a = ay_q; mul_b = ay_q; end
				default: begin mul_a = az_q; mul_b = az_q; end
			endcase
		end else begin
			// square of each magnitude from three half-width partial products
			case (cmd.cnt[3:0])
				4'd0: begin
					mul_a = 32'(mag_x[ACC_W-1:HALF_W]); mul_b = mul_a; sh = 8'(2*HALF_W);
				end
				4'd1: begin
					mul_a = 32'(mag_x[ACC_W-1:HALF_W]); mul_b = 32'(mag_x[HALF_W-1:0]);
					sh = 8'(HALF_W + 1);
				end
				4'd2: begin mul_a = 32'(mag_x[HALF_W-1:0]); mul_b = mul_a; end
				4'd3: begin
					mul_a = 32'(mag_y[ACC_W-1:HALF_W]); mul_b = mul_a; sh = 8'(2*HALF_W);
				end
				4'd4: begin
					mul_a = 32'(mag_y[ACC_W-1:HALF_W]); mul_b = 32'(mag_y[HALF_W-1:0]);
					sh = 8'(HALF_W + 1);
				end
				4'd5: begin mul_a = 32'(mag_y[HALF_W-1:0]); mul_b = mul_a; end
				4'd6: begin
					mul_a = 32'(mag_z[ACC_W-1:HALF_W]); mul_b = mul_a; sh = 8'(2*HALF_W);
				end
				4'd7: begin
					mul_a = 32'(mag_z[ACC_W-1:HALF_W]); mul_b = 32'(mag_z[HALF_W-1:0]);
					sh = 8'(HALF_W + 1);
				end
				default: begin mul_a = 32'(mag_z[HALF_W-1:0]); mul_b = mul_a; end
			endcase
		end
	end

	assign prod    = 64'(mul_a) * 64'(mul_b);
	assign prod_sh = SQ_W'(prod) << sh;

	// gate sums
	logic [63:0] rr_q, dsum_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			if (cmd.first) rr_q <= prod;
			else if (cmd.cnt == CNT_W'(1)) dsum_q <= prod;
			else dsum_q <= dsum_q + prod;
		end
	end

	// saturating accumulate of the signed impulse
	logic               counted;
	logic signed [32:0] vx, vy, vz;
	logic signed [ACC_W:0] sx, sy, sz;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
		logic signed [ACC_W-1:0] r;
		if (s[ACC_W] != s[ACC_W-1])
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			r = s[ACC_W-1:0];
		return r;
	endfunction

	assign counted = (radius_q <= 0) || (!outside_q && dsum_q < rr_q);
	assign vx = item_q.sensor_is_second ? -33'(item_q.imp_x) : 33'(item_q.imp_x);
	assign vy = item_q.sensor_is_second ? -33'(item_q.imp_y) : 33'(item_q.imp_y);
	assign vz = item_q.sensor_is_second ? -33'(item_q.imp_z) : 33'(item_q.imp_z);
	assign sx = (ACC_W+1)'(acc_x_q) + (ACC_W+1)'(vx);
	assign sy = (ACC_W+1)'(acc_y_q) + (ACC_W+1)'(vy);
	assign sz = (ACC_W+1)'(acc_z_q) + (ACC_W+1)'(vz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			wdt_q   <= '0;
		end else if (cmd.emit) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			wdt_q   <= '0;
		end else if (cmd.acc && counted) begin
			acc_x_q <= sat_acc(sx);
			acc_y_q <= sat_acc(sy);
			acc_z_q <= sat_acc(sz);
			if (item_q.contact_dt != '0) wdt_q <= item_q.contact_dt;
		end
	end

	// serial square root, two bits of S a step
	logic [SQ_W-1:0]  s_q;
	logic             szero_q;
	logic [ACC_W+1:0] rem_q, rem_b, rem_n, trial;
	logic [ACC_W-1:0] root_q, root_b;

	assign rem_b  = cmd.first ? '0 : rem_q;
	assign root_b = cmd.first ? '0 : root_q;
	assign rem_n  = {rem_b[ACC_W-1:0], s_q[SQ_W-1:SQ_W-2]};
	assign trial  = {root_b, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			s_q <= cmd.first ? prod_sh : s_q + prod_sh;
		end else if (cmd.sqrt) begin
			if (cmd.first) szero_q <= (s_q == '0);
			s_q <= {s_q[SQ_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_b[ACC_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_b[ACC_W-2:0], 1'b0};
			end
		end
	end

	// serial divide of M * 2^24 by dt, one quotient bit a step
	logic [31:0]        dsel;
	logic [MH_W-1:0]    mh;
	logic [31:0]        drem_q, drem_b;
	logic [32:0]        drem_n;
	logic [FORCE_W-1:0] nb_q, nb_b, quo_q;
	logic               sat_q;

	assign dsel   = (wdt_q != '0) ? wdt_q : ((step_dt_q != '0) ? step_dt_q : DT_SIXTIETH);
	assign mh     = root_q[ACC_W-1:LOW_W];
	assign drem_b = cmd.first ? 32'(mh) : drem_q;
	assign nb_b   = cmd.first ? {root_q[LOW_W-1:0], {DT_FRAC{1'b0}}} : nb_q;
	assign drem_n = {drem_b, nb_b[FORCE_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			if (cmd.first) sat_q <= (CMP_W'(mh) >= CMP_W'(dsel));
			nb_q <= {nb_b[FORCE_W-2:0], 1'b0};
			if (drem_n >= {1'b0, dsel}) begin
				drem_q <= 32'(drem_n - {1'b0, dsel});
				quo_q  <= {quo_q[FORCE_W-2:0], 1'b1};
			end else begin
				drem_q <= drem_n[31:0];
				quo_q  <= {quo_q[FORCE_W-2:0], 1'b0};
			end
		end
	end

	// clamp, threshold and output register
	logic [FORCE_W-1:0] f_sat, f_clamp;
	logic               hit;

	assign f_sat   = sat_q ? {FORCE_W{1'b1}} : quo_q;
	assign f_clamp = (f_sat > max_th_q) ? max_th_q : f_sat;
	assign hit     = !szero_q && (f_clamp >= min_th_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				KIND_FORCE: begin
					out_data.force_res  <= hit ? f_clamp : '0;
					out_data.in_contact <= hit;
					out_data.valid_res  <= 1'b1;
				end
				KIND_OFF: begin
					out_data.force_res  <= '0;
					out_data.in_contact <= 1'b0;
					out_data.valid_res  <= 1'b0;
				end
				default: begin
					out_data.force_res  <= '0;
					out_data.in_contact <= 1'b0;
					out_data.valid_res  <= enable_q;
				end
			endcase
		end
	end

endmodule

[design/contact_force_accumulator.sv]
// Contact force accumulator top level: controller plus datapath.
// Sequence: a contact is accepted, gated, takes four multiplier passes and is
// accumulated; a last item with the sensor enabled adds 9 square passes, 48
// sqrt and 40 divide steps, and its result goes into the output register
// once that is free; only then is the next item taken. A disabled last item
// goes there after accumulating, and an empty step after accept and gate.
// Throughput: one item at a time; set by the shared multiplier and the
// bit-serial sqrt and divider. A finished result waits in an output register.
// Reset: asynchronous, clears state and accumulators; config registers take their defaults.
module contact_force_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cfa_pkg::cfa_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cfa_pkg::cfa_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cfa_pkg::*;

	cfa_cmd_t  cmd;
	cfa_stat_t stat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	cfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
